/* hdl/uis_pkg.sv */
// Shared constants, op codes and beat types for the unsorted integer set.
package uis_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ENTRIES_W = 7;

  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
  localparam logic [OP_W-1:0] OP_ITERATE  = 3'd4;
  localparam logic [OP_W-1:0] OP_DRAIN    = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_value;
    logic                     has_item;
    logic                     found;
    logic                     refused_full;
    logic [ENTRIES_W-1:0]     entries;
    logic                     is_last;
  } out_t;

endpackage

/* hdl/unsorted_integer_set.sv */
// Top level of the unsorted integer set: sequencer, entry RAM and output register.
// The set keeps up to CAPACITY distinct 32-bit values in one RAM with a single
// read port and a count register, and works on one op at a time. Add, remove
// and contains scan the entries linearly, one RAM read per cycle; remove then
// moves the last entry into the hole. Iterate and drain read ahead one entry
// and then give one result beat per cycle while the output register has room.
// An empty iterate or drain gives a single beat with has_item low. A finished
// beat waits in the output register while the next op is taken; the RAM
// contents are undefined after reset and need no clearing, as only entries
// below the count are ever read.
module unsorted_integer_set import uis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_MOVE_RD = 3'd2;
  localparam logic [2:0] S_MOVE_WR = 3'd3;
  localparam logic [2:0] S_RESP    = 3'd4;
  localparam logic [2:0] S_ITER    = 3'd5;
  localparam logic [2:0] S_DRAIN   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              pend_q, pend_d;
  logic              found_q, found_d;
  logic              full_q, full_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  logic              room, push, hit;
  out_t              push_data;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2, idx_p1;

  uis_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign room   = !out_valid_q || out_ready_i;
  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign cnt_m2 = cnt_q - CNT_W'(2);
  assign idx_p1 = idx_q + CNT_W'(1);
  // rd_data belongs to the entry at slot_q whenever pend_q is set
  assign hit    = pend_q && (rd_data == val_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    pend_d    = pend_q;
    found_d   = found_q;
    full_d    = full_q;
    op_d      = op_q;
    val_d     = val_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = slot_q;
    wr_data   = rd_data;
    push      = 1'b0;
    push_data = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.op;
          val_d   = in_data_i.value;
          found_d = 1'b0;
          full_d  = 1'b0;
          idx_d   = '0;
          pend_d  = 1'b0;
          case (in_data_i.op)
            OP_ADD, OP_REMOVE, OP_CONTAINS: begin
              state_d = S_SEARCH;
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_RESP;
            end
            OP_ITERATE: begin
              if (cnt_q == '0) begin
                state_d = S_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = S_ITER;
              end
            end
            OP_DRAIN: begin
              if (cnt_q == '0) begin
                state_d = S_RESP;
              end else begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[IDX_W-1:0];
                state_d = S_DRAIN;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          pend_d  = 1'b0;
          found_d = 1'b1;
          state_d = (op_q == OP_REMOVE) ? S_MOVE_RD : S_RESP;
        end else if (idx_q < cnt_q) begin
          // advance the scan; compare lands next cycle
          rd_en   = 1'b1;
          rd_addr = idx_q[IDX_W-1:0];
          slot_d  = idx_q[IDX_W-1:0];
          idx_d   = idx_p1;
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_RESP;
          if (op_q == OP_ADD) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              full_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_q[IDX_W-1:0];
              wr_data = val_q;
              cnt_d   = cnt_q + CNT_W'(1);
            end
          end
        end
      end

      S_MOVE_RD: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[IDX_W-1:0];
        cnt_d   = cnt_m1;
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // fill the hole with the former last entry
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = rd_data;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (room) begin
          push                   = 1'b1;
          push_data.found        = found_q;
          push_data.refused_full = full_q;
          push_data.entries      = ENTRIES_W'(cnt_q);
          push_data.is_last      = 1'b1;
          state_d                = S_IDLE;
        end
      end

      S_ITER: begin
        if (room) begin
          push                 = 1'b1;
          push_data.item_value = rd_data;
          push_data.has_item   = 1'b1;
          push_data.entries    = ENTRIES_W'(cnt_q);
          push_data.is_last    = (idx_p1 == cnt_q);
          if (idx_p1 == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_p1[IDX_W-1:0];
            idx_d   = idx_p1;
          end
        end
      end

      S_DRAIN: begin
        if (room) begin
          push                 = 1'b1;
          push_data.item_value = rd_data;
          push_data.has_item   = 1'b1;
          push_data.entries    = ENTRIES_W'(cnt_m1);
          push_data.is_last    = (cnt_m1 == '0);
          cnt_d                = cnt_m1;
          if (cnt_m1 == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[IDX_W-1:0];
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    found_q <= found_d;
    full_q  <= full_d;
    op_q    <= op_d;
    val_q   <= val_d;
    out_q   <= out_d;
  end

endmodule

/* hdl/uis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

/* verif/tb_unsorted_integer_set.sv */
// Self-checking bench for the unsorted integer set: directed table, random ops and fill bursts.
module tb_unsorted_integer_set;
  timeunit 1ns;
  timeprecision 1ps;
  import uis_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int POOL_SIZE = 80;
  localparam int FILL_ADDS = 70;
  localparam int FILL_OPS  = FILL_ADDS + 14;
  localparam int IDLE_PCT  = 28;
  localparam int OP_TARGET = 310;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    bit                typed;
    out_t              want;
  } table_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  logic [DATA_W-1:0] mirror_store [CAPACITY];
  int                mirror_count = 0;
  out_t              pending_results [$];
  int                mismatches = 0;
  int                ops_sent = 0;
  bit                quiet_phase;
  bit                beat_typed;
  out_t              beat_want;
  logic [DATA_W-1:0] value_pool [POOL_SIZE];
  table_row_t        directed_rows [$];

  unsorted_integer_set dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_t status_beat(bit found, bit full, int count);
    out_t r;
    r = '0;
    r.found        = found;
    r.refused_full = full;
    r.entries      = count[ENTRIES_W-1:0];
    r.is_last      = 1'b1;
    return r;
  endfunction

  function automatic string beat_text(out_t b);
    return $sformatf({"item_value=%0d has_item=%0b found=%0b refused_full=%0b ",
                      "entries=%0d is_last=%0b"},
                     b.item_value, b.has_item, b.found, b.refused_full, b.entries, b.is_last);
  endfunction

  // Update the set mirror for one op and list the beats it must produce.
  function automatic void apply_set_op(input in_t beat, ref out_t outs[$]);
    int   slot;
    bit   refuse;
    out_t r;
    slot = -1;
    for (int i = mirror_count - 1; i >= 0; i--)
      if (mirror_store[i] == beat.value) slot = i;
    case (beat.op)
      OP_ADD: begin
        refuse = (slot < 0) && (mirror_count >= CAPACITY);
        if (slot < 0 && !refuse) begin
          mirror_store[mirror_count] = beat.value;
          mirror_count++;
        end
        outs.push_back(status_beat(slot >= 0, refuse, mirror_count));
      end
      OP_REMOVE: begin
        // fill the hole with the last entry
        if (slot >= 0) begin
          mirror_count--;
          mirror_store[slot] = mirror_store[mirror_count];
        end
        outs.push_back(status_beat(slot >= 0, 1'b0, mirror_count));
      end
      OP_CONTAINS: outs.push_back(status_beat(slot >= 0, 1'b0, mirror_count));
      OP_CLEAR: begin
        mirror_count = 0;
        outs.push_back(status_beat(1'b0, 1'b0, 0));
      end
      OP_ITERATE: begin
        if (mirror_count == 0) begin
          outs.push_back(status_beat(1'b0, 1'b0, 0));
        end else begin
          for (int n = 0; n < mirror_count; n++) begin
            r            = '0;
            r.item_value = mirror_store[n];
            r.has_item   = 1'b1;
            r.entries    = mirror_count[ENTRIES_W-1:0];
            r.is_last    = (n == mirror_count - 1);
            outs.push_back(r);
          end
        end
      end
      OP_DRAIN: begin
        if (mirror_count == 0) begin
          outs.push_back(status_beat(1'b0, 1'b0, 0));
        end else begin
          while (mirror_count > 0) begin
            mirror_count--;
            r            = '0;
            r.item_value = mirror_store[mirror_count];
            r.has_item   = 1'b1;
            r.entries    = mirror_count[ENTRIES_W-1:0];
            r.is_last    = (mirror_count == 0);
            outs.push_back(r);
          end
        end
      end
      default: outs.push_back(status_beat(1'b0, 1'b0, mirror_count));
    endcase
  endfunction

  task automatic table_row(logic [OP_W-1:0] op, logic [DATA_W-1:0] value, bit typed,
                           bit found = 1'b0, bit full = 1'b0, int count = 0);
    table_row_t r;
    r.op    = op;
    r.value = value;
    r.typed = typed;
    r.want  = status_beat(found, full, count);
    directed_rows.push_back(r);
  endtask

  // Present one beat, idling first at random outside the quiet window, and hold it until accepted.
  task automatic send_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                         bit typed = 1'b0, out_t want = '0);
    in_t beat;
    bit  calm;
    beat.op    = op;
    beat.value = value;
    calm = (ops_sent >= 150) && (ops_sent < 230);
    quiet_phase <= calm;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk_i); while (!in_ready_o);
    ops_sent++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : result_check
    out_t step_results [$];
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        step_results = {};
        apply_set_op(in_data_i, step_results);
        if (beat_typed) pending_results.push_back(beat_want);
        else foreach (step_results[k]) pending_results.push_back(step_results[k]);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, actual %s",
                   $time, beat_text(out_data_o));
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.item_value !== want.item_value ||
              out_data_o.has_item !== want.has_item ||
              out_data_o.found !== want.found ||
              out_data_o.refused_full !== want.refused_full ||
              out_data_o.entries !== want.entries ||
              out_data_o.is_last !== want.is_last) begin
            mismatches++;
            $display("%0t: result mismatch, expected %s, actual %s",
                     $time, beat_text(want), beat_text(out_data_o));
          end
        end
      end
    end
  end

  initial begin
    int                pick;
    int                base;
    bit                dup;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    quiet_phase <= 1'b0;
    beat_typed  <= 1'b0;
    beat_want   <= '0;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      do begin
        value_pool[i] = $urandom;
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (value_pool[j] == value_pool[i]) dup = 1'b1;
      end while (dup);
    end

    table_row(OP_ITERATE,  32'h0000_0000, 1'b1);
    table_row(OP_DRAIN,    32'hFFFF_FFFF, 1'b1);
    table_row(OP_CONTAINS, 32'h0000_0000, 1'b1);
    table_row(OP_REMOVE,   32'h0000_0005, 1'b1);
    table_row(OP_ADD,      32'h8000_0000, 1'b1, 1'b0, 1'b0, 1);
    table_row(OP_ADD,      32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 2);
    table_row(OP_ADD,      32'h0000_0000, 1'b1, 1'b0, 1'b0, 3);
    table_row(OP_ADD,      32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 4);
    table_row(OP_ADD,      32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 4);
    table_row(OP_CONTAINS, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 4);
    table_row(OP_CONTAINS, 32'h8000_0001, 1'b1, 1'b0, 1'b0, 4);
    table_row(OP_ITERATE,  32'h5A5A_5A5A, 1'b0);
    // first slot goes, last entry moves into it
    table_row(OP_REMOVE,   32'h8000_0000, 1'b1, 1'b1, 1'b0, 3);
    table_row(OP_ITERATE,  32'hA5A5_A5A5, 1'b0);
    table_row(OP_SPARE_LO, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 3);
    table_row(OP_SPARE_HI, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 3);
    table_row(OP_REMOVE,   32'h0000_0000, 1'b1, 1'b1, 1'b0, 2);
    table_row(OP_REMOVE,   32'h0000_0000, 1'b1, 1'b0, 1'b0, 2);
    table_row(OP_DRAIN,    32'h0000_0000, 1'b0);
    table_row(OP_ITERATE,  32'h0000_0000, 1'b1);
    table_row(OP_ADD,      32'h0000_0001, 1'b1, 1'b0, 1'b0, 1);
    table_row(OP_ADD,      32'h0000_0002, 1'b1, 1'b0, 1'b0, 2);
    table_row(OP_CLEAR,    32'hFFFF_FFFF, 1'b1);
    table_row(OP_CONTAINS, 32'h0000_0001, 1'b1);
    table_row(OP_DRAIN,    32'h0000_0000, 1'b1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].value,
              directed_rows[i].typed, directed_rows[i].want);

    for (int blk = 0; ops_sent < OP_TARGET; blk++) begin
      if (blk % 4 == 1 && ops_sent + FILL_OPS <= OP_TARGET) begin
        // fill past capacity, then probe, thin out and drain
        base = $urandom_range(0, POOL_SIZE - 1);
        send_op(OP_CLEAR, $urandom);
        for (int i = 0; i < FILL_ADDS; i++) send_op(OP_ADD, value_pool[(base + i) % POOL_SIZE]);
        send_op(OP_ADD, value_pool[base]);
        send_op(OP_ITERATE, $urandom);
        repeat (8) send_op(OP_REMOVE, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
        send_op(OP_CONTAINS, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
        send_op(OP_ADD, $urandom);
        send_op(OP_DRAIN, $urandom);
      end else begin
        repeat (15) begin
          pick  = $urandom_range(0, 99);
          value = ($urandom_range(0, 4) == 0) ? $urandom
                                              : value_pool[$urandom_range(0, POOL_SIZE - 1)];
          if (pick < 35)      op = OP_ADD;
          else if (pick < 55) op = OP_REMOVE;
          else if (pick < 72) op = OP_CONTAINS;
          else if (pick < 75) op = OP_CLEAR;
          else if (pick < 85) op = OP_ITERATE;
          else if (pick < 92) op = OP_DRAIN;
          else if (pick < 96) op = OP_SPARE_LO;
          else                op = OP_SPARE_HI;
          send_op(op, value);
        end
      end
    end
    in_valid_i <= 1'b0;

    // let the checker log the last accepted beat first
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* unsorted_integer_set.f */
hdl/uis_pkg.sv
hdl/uis_ram.sv
hdl/unsorted_integer_set.sv
verif/tb_unsorted_integer_set.sv
